// ===== hw/rtl/fpfa_pkg.sv =====
// Shared constants and codes for the fixed-partition fit allocator.
`timescale 1ns / 1ps

package fpfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// command codes
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_ALLOC   = 2'd2;

	// fit policy codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// register index taken from paddr[2]
	localparam logic REG_FIT_POLICY  = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 1;

endpackage

// ===== hw/rtl/fixed_partition_fit_allocator_top.sv =====
// Top level of the fixed-partition fit allocator: command intake, scan sequencer, output beat.
//
// channel  | signals                          | role
// ---------+----------------------------------+-------------------------------------------
// s_       | tvalid tready tdata[23:0] tuser  | commands: write size, release all, allocate
// m_       | tvalid tready tdata[39:0] tuser  | one result beat per command
// apb      | psel penable pwrite paddr pwdata | fit_policy at 0x0, block_count at 0x4
//
// Write, release and unused commands go straight from accept to the done state, which loads the result beat.
// Allocate first scans the table (block_count capped at MAX_BLOCKS):
// the table RAM read port is stepped one entry per cycle through a single fit comparator.
// s_tready is high only while the sequencer is idle; a held result beat does not block intake.
// A result waits in the sequencer while the output register is still full.
// Reset clears used marks, registers and control; table contents stay undefined until written.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_top #(
	parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fpfa_pkg::S_TDATA_W-1:0]  s_tdata,  // entry_index[3:0], size[19:4], zero pad
	input  logic [fpfa_pkg::S_TUSER_W-1:0]  s_tuser,  // command[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fpfa_pkg::M_TDATA_W-1:0]  m_tdata,  // chosen_block[3:0], block_size[19:4],
	                                                   // leftover[35:20], zero pad
	output logic [fpfa_pkg::M_TUSER_W-1:0]  m_tuser,  // granted[0]
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	// configuration
	logic [1:0] fit_policy_q;
	logic [4:0] block_count_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == fpfa_pkg::REG_BLOCK_COUNT) ? 32'(block_count_q)
	                                                        : 32'(fit_policy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= fpfa_pkg::POL_FIRST;
			block_count_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == fpfa_pkg::REG_FIT_POLICY) begin
				fit_policy_q <= pwdata[1:0];
			end else begin
				block_count_q <= pwdata[4:0];
			end
		end
	end

	// input fields
	logic [1:0]           in_cmd;
	logic [3:0]           in_entry;
	logic [15:0]          in_size;
	logic                 in_acc;
	logic [SIZE_BITS-1:0] in_req;

	assign in_cmd   = s_tuser[1:0];
	assign in_entry = s_tdata[3:0];
	assign in_size  = s_tdata[19:4];
	assign in_req   = SIZE_BITS'(in_size);
	assign in_acc   = s_tvalid & s_tready;

	// sequencer state
	state_t               state_q;
	logic [CNT_W-1:0]     issue_q;
	logic                 eval_q;
	logic [IDX_W-1:0]     eval_idx_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic                 m_tvalid_q;
	logic                 granted_q;
	logic [3:0]           chosen_q;
	logic [15:0]          bsize_q;
	logic [15:0]          left_q;

	logic [CNT_W-1:0]     limit;
	logic                 rd_en;
	logic [SIZE_BITS-1:0] rd_data;
	logic                 wr_en;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 out_free;
	logic [SIZE_BITS-1:0] left_w;

	always_comb begin
		if (32'(block_count_q) > 32'(MAX_BLOCKS)) begin
			limit = CNT_W'(MAX_BLOCKS);
		end else begin
			limit = CNT_W'(block_count_q);
		end
	end

	assign wr_en = in_acc && (in_cmd == fpfa_pkg::CMD_WRITE) &&
	               (32'(in_entry) < 32'(MAX_BLOCKS));
	assign rd_en = (state_q == ST_SCAN) && (issue_q < limit);

	fpfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(in_entry)),
		.wr_data (in_req),
		.rd_en   (rd_en),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// shared fit comparator
	always_comb begin
		fits = !used_q[eval_idx_q] && (rd_data >= req_q);
		case (fit_policy_q)
			fpfa_pkg::POL_BEST:  better = rd_data < best_size_q;
			fpfa_pkg::POL_WORST: better = rd_data > best_size_q;
			default:             better = 1'b0;
		endcase
		take = eval_q && fits && (!found_q || better);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign left_w   = best_size_q - req_q;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			eval_q      <= 1'b0;
			eval_idx_q  <= '0;
			req_q       <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_size_q <= '0;
			used_q      <= '0;
			m_tvalid_q  <= 1'b0;
			granted_q   <= 1'b0;
			chosen_q    <= '0;
			bsize_q     <= '0;
			left_q      <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						req_q   <= in_req;
						found_q <= 1'b0;
						issue_q <= '0;
						eval_q  <= 1'b0;
						if (in_cmd == fpfa_pkg::CMD_RELEASE) begin
							used_q <= '0;
						end
						if (in_cmd == fpfa_pkg::CMD_ALLOC) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					eval_q     <= rd_en;
					eval_idx_q <= issue_q[IDX_W-1:0];
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (take) begin
						found_q     <= 1'b1;
						best_idx_q  <= eval_idx_q;
						best_size_q <= rd_data;
					end
					if (!rd_en && !eval_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						granted_q  <= found_q;
						if (found_q) begin
							used_q[best_idx_q] <= 1'b1;
							chosen_q <= 4'(best_idx_q);
							bsize_q  <= 16'(best_size_q);
							left_q   <= 16'(left_w);
						end else begin
							chosen_q <= '0;
							bsize_q  <= '0;
							left_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = granted_q;
	assign m_tdata  = {4'b0, left_q, bsize_q, chosen_q};

	// a refused or non-allocate beat carries all zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("refused result carries nonzero data");

	// a grant never reports more leftover than block size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[35:20] <= m_tdata[19:4])
		else $error("leftover exceeds block size");

	// at most one block is marked used per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) <= $countones($past(used_q)) + 1)
		else $error("more than one used mark set at once");

	// the picked block is still free when the grant is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && found_q |-> !used_q[best_idx_q])
		else $error("granting a block already in use");

	// scan never reads beyond the configured block count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> issue_q <= limit)
		else $error("scan index ran past block count");

endmodule

// ===== hw/rtl/fpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
